[rtl/core/rfcc_pkg.sv]
// ----------------------------------------------------------------------------
// rfcc_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// response frame CRC checker.
// ----------------------------------------------------------------------------
package rfcc_pkg;

    localparam int MAX_PAYLOAD = 1024;
    localparam int LEN_W       = 11;
    localparam int POS_W       = $clog2(MAX_PAYLOAD + 3);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  START_BYTE = 8'hC5;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_PAYLOAD,
        KIND_CRC_HI,
        KIND_CRC_LO
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_START = 2'd1,
        STATUS_BAD_CRC   = 2'd2
    } status_t;

    // classified word handed from front to back
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } rfcc_word_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

[rtl/core/response_frame_crc_checker_unit.sv]
// ----------------------------------------------------------------------------
// response_frame_crc_checker_unit
// Checks response frames: start byte, payload passed through, CRC-16 check.
// ----------------------------------------------------------------------------
// Path: an accepted word is written into the queue, then popped into the
//   output register, where it is held while out_stall is high.
// Throughput: one word per cycle while the output is not stalled; the front
//   position counter and the back byte-wide CRC update each handle a whole word at once.
// Reset: rst_n is asynchronous, active low; clears the position, queue and
//   output valid, sets the CRC state to CRC_INIT and the payload length to 1024.
// ----------------------------------------------------------------------------
module response_frame_crc_checker_unit
    import rfcc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // received byte channel
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       rx_byte,
    // payload length register
    input  logic             cfg_write_en,
    input  logic [LEN_W-1:0] cfg_write_data,
    // result channel
    output logic             out_valid,
    input  logic             out_stall,
    output logic             payload_valid,
    output logic [7:0]       payload_byte,
    output logic             frame_done,
    output logic [1:0]       frame_status
);

    // front -> queue
    logic       push;
    rfcc_word_t push_word;
    logic       queue_full;

    // queue -> back
    rfcc_word_t head_word;
    logic       queue_empty;
    logic       pop;

    // Front: classifies each word by its frame position. It depends only on
    // position and length, so it runs ahead of the CRC state in the back.
    rfcc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .queue_full     (queue_full),
        .push           (push),
        .push_word      (push_word)
    );

    // Two-entry queue: front keeps taking words while the output is stalled.
    rfcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // Back: CRC accumulate, start/CRC check, output register.
    rfcc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_word     (head_word),
        .queue_empty   (queue_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .frame_done    (frame_done),
        .frame_status  (frame_status)
    );

endmodule

[rtl/core/rfcc_front.sv]
// ----------------------------------------------------------------------------
// rfcc_front
// Accepts received bytes, tracks the position in the frame and tags each
// word as start, payload, CRC high or CRC low. Holds the length register.
// ----------------------------------------------------------------------------
module rfcc_front
    import rfcc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       rx_byte,
    input  logic             cfg_write_en,
    input  logic [LEN_W-1:0] cfg_write_data,
    input  logic             queue_full,
    output logic             push,
    output rfcc_word_t       push_word
);

    logic [LEN_W-1:0] length_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] len_eff;
    kind_t            kind;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        if (int'(length_reg) > MAX_PAYLOAD)
            len_eff = POS_W'(MAX_PAYLOAD);
        else
            len_eff = POS_W'(length_reg);
    end

    always_comb
    begin
        if (pos_reg == '0)
        begin
            kind     = KIND_START;
            pos_next = POS_W'(1);
        end
        else if (pos_reg <= len_eff)
        begin
            kind     = KIND_PAYLOAD;
            pos_next = pos_reg + POS_W'(1);
        end
        else if ({1'b0, pos_reg} == ({1'b0, len_eff} + (POS_W + 1)'(1)))
        begin
            kind     = KIND_CRC_HI;
            pos_next = pos_reg + POS_W'(1);
        end
        else
        begin
            kind     = KIND_CRC_LO;
            pos_next = '0;
        end
    end

    assign push_word.kind = kind;
    assign push_word.data = rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= LEN_W'(MAX_PAYLOAD);
            pos_reg    <= '0;
        end
        else
        begin
            if (cfg_write_en)
                length_reg <= cfg_write_data;
            if (push)
                pos_reg <= pos_next;
        end
    end

endmodule

[rtl/core/rfcc_queue.sv]
// ----------------------------------------------------------------------------
// rfcc_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module rfcc_queue
    import rfcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  rfcc_word_t push_word,
    input  logic       pop,
    output rfcc_word_t head_word,
    output logic       full,
    output logic       empty
);

    rfcc_word_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_word = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0
                                                                    : wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0
                                                                    : rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/rfcc_back.sv]
// ----------------------------------------------------------------------------
// rfcc_back
// Runs the CRC over payload words, checks start byte and CRC, and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module rfcc_back
    import rfcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rfcc_word_t head_word,
    input  logic       queue_empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       payload_valid,
    output logic [7:0] payload_byte,
    output logic       frame_done,
    output logic [1:0] frame_status
);

    logic        out_valid_reg;
    logic        payload_valid_reg, payload_valid_next;
    logic [7:0]  payload_byte_reg, payload_byte_next;
    logic        frame_done_reg, frame_done_next;
    status_t     status_reg, status_next;
    logic [15:0] crc_reg, crc_next;
    logic        bad_start_reg, bad_start_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;

    assign pop = !queue_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        payload_valid_next = 1'b0;
        payload_byte_next  = 8'h00;
        frame_done_next    = 1'b0;
        status_next        = STATUS_OK;
        crc_next           = crc_reg;
        bad_start_next     = bad_start_reg;
        crc_hi_next        = crc_hi_reg;
        unique case (head_word.kind)
            KIND_START:
            begin
                bad_start_next = (head_word.data != START_BYTE);
                crc_next       = CRC_INIT;
            end
            KIND_PAYLOAD:
            begin
                payload_valid_next = 1'b1;
                payload_byte_next  = head_word.data;
                crc_next           = crc16_byte(crc_reg, head_word.data);
            end
            KIND_CRC_HI:
                crc_hi_next = head_word.data;
            KIND_CRC_LO:
            begin
                frame_done_next = 1'b1;
                if (bad_start_reg)
                    status_next = STATUS_BAD_START;
                else if ({crc_hi_reg, head_word.data} != crc_reg)
                    status_next = STATUS_BAD_CRC;
                crc_next       = CRC_INIT;
                bad_start_next = 1'b0;
                crc_hi_next    = 8'h00;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            crc_reg       <= CRC_INIT;
            bad_start_reg <= 1'b0;
            crc_hi_reg    <= 8'h00;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                crc_reg       <= crc_next;
                bad_start_reg <= bad_start_next;
                crc_hi_reg    <= crc_hi_next;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            payload_valid_reg <= payload_valid_next;
            payload_byte_reg  <= payload_byte_next;
            frame_done_reg    <= frame_done_next;
            status_reg        <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_valid = payload_valid_reg;
    assign payload_byte  = payload_byte_reg;
    assign frame_done    = frame_done_reg;
    assign frame_status  = status_reg;

endmodule

[rtl/core/rfcc_checker.sv]
// ----------------------------------------------------------------------------
// rfcc_checker
// Port-level assertions for the response frame CRC checker, bound to the top.
// ----------------------------------------------------------------------------
module rfcc_checker
    import rfcc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       payload_valid,
    input logic [7:0] payload_byte,
    input logic       frame_done,
    input logic [1:0] frame_status
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a word is payload or CRC end, never both
    a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(payload_valid && frame_done))
        else $error("payload and frame end on one word");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !payload_valid |-> payload_byte == 8'h00)
        else $error("payload byte not cleared");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_done || frame_status == STATUS_OK) &&
                      frame_status <= STATUS_BAD_CRC)
        else $error("bad frame status");

endmodule

bind response_frame_crc_checker_unit rfcc_checker u_rfcc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .frame_done    (frame_done),
    .frame_status  (frame_status)
);

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the response frame CRC checker. A tracker class
// follows the frame state and CRC-16 of every accepted byte and predicts the
// result word for it. Results are checked in order, field by field.
// Stimulus is a short directed set of frames, then random frames under three
// idle/stall mixes with length changes, mid-frame length changes, noise and
// one saturating maximum-length frame.
// ----------------------------------------------------------------------------
module tb_top;
    import rfcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------------
    // Frame tracker: own copy of the length register and of the frame state.
    // accept_byte() predicts the result word of one accepted byte,
    // check_result() compares one accepted result word with the oldest one.
    // ------------------------------------------------------------------------
    class frame_tracker;
        typedef struct {
            logic       pay_valid;
            logic [7:0] pay_byte;
            logic       done;
            status_t    status;
        } frame_result_t;

        frame_result_t    pending_results[$];
        logic [LEN_W-1:0] length_reg;
        int unsigned      position;
        logic [15:0]      crc_run;
        logic             start_bad;
        logic [7:0]       crc_hi_rx;
        int unsigned      error_count;

        function new();
            length_reg  = LEN_W'(MAX_PAYLOAD);
            error_count = 0;
            restart();
        endfunction

        function void restart();
            position  = 0;
            crc_run   = CRC_INIT;
            start_bad = 1'b0;
            crc_hi_rx = 8'h00;
        endfunction

        // CRC-16/CCITT-FALSE, one data bit per step, MSB first
        static function logic [15:0] crc_step(input logic [15:0] crc,
                                              input logic [7:0]  data);
            logic [15:0] c;
            logic        fb;
            c = crc;
            for (int i = 7; i >= 0; i--)
            begin
                fb = c[15] ^ data[i];
                c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
            end
            return c;
        endfunction

        // lengths above the maximum saturate
        function int unsigned effective_length();
            if (length_reg > MAX_PAYLOAD)
                return MAX_PAYLOAD;
            return length_reg;
        endfunction

        function void accept_byte(input logic [7:0] b);
            frame_result_t r;
            int unsigned   len;
            len         = effective_length();
            r.pay_valid = 1'b0;
            r.pay_byte  = 8'h00;
            r.done      = 1'b0;
            r.status    = STATUS_OK;
            if (position == 0)
            begin
                start_bad = (b != START_BYTE);
                crc_run   = CRC_INIT;
                position  = 1;
            end
            else if (position <= len)
            begin
                r.pay_valid = 1'b1;
                r.pay_byte  = b;
                crc_run     = crc_step(crc_run, b);
                position++;
            end
            else if (position == len + 1)
            begin
                crc_hi_rx = b;
                position++;
            end
            else
            begin
                // last CRC byte, also taken when a shorter length moved the
                // payload end behind the current position
                r.done = 1'b1;
                if (start_bad)
                    r.status = STATUS_BAD_START;
                else if ({crc_hi_rx, b} != crc_run)
                    r.status = STATUS_BAD_CRC;
                restart();
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(input logic       pv,
                                   input logic [7:0] pb,
                                   input logic       fd,
                                   input logic [1:0] fs);
            frame_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count++;
                return;
            end
            e = pending_results.pop_front();
            if (pv !== e.pay_valid)
            begin
                $error("payload_valid: expected %0d, actual %0d", e.pay_valid, pv);
                error_count++;
            end
            if (pb !== e.pay_byte)
            begin
                $error("payload_byte: expected %02h, actual %02h", e.pay_byte, pb);
                error_count++;
            end
            if (fd !== e.done)
            begin
                $error("frame_done: expected %0d, actual %0d", e.done, fd);
                error_count++;
            end
            if (fs !== e.status)
            begin
                $error("frame_status: expected %0d, actual %0d", e.status, fs);
                error_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic             clk            = 1'b0;
    logic             rst_n          = 1'b0;
    logic             in_valid       = 1'b0;
    logic             in_stall;
    logic [7:0]       rx_byte        = 8'h00;
    logic             cfg_write_en   = 1'b0;
    logic [LEN_W-1:0] cfg_write_data = '0;
    logic             out_valid;
    logic             out_stall      = 1'b0;
    logic             payload_valid;
    logic [7:0]       payload_byte;
    logic             frame_done;
    logic [1:0]       frame_status;

    frame_tracker tracker;

    // idle mix, set per phase by the stimulus
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned items_sent     = 0;

    // long receiver hold-off: requested by the stimulus, run by the receiver
    bit          hold_go   = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;

    response_frame_crc_checker_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_valid  (payload_valid),
        .payload_byte   (payload_byte),
        .frame_done     (frame_done),
        .frame_status   (frame_status)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall per cycle, or a counted hold-off stretch. While
    // held, the sender keeps offering, so the internal queue fills and the
    // block must stall its input.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = 80;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result monitor: values read right after the edge are the pre-edge ones,
    // since everything on both sides changes by nonblocking update.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(payload_valid, payload_byte, frame_done, frame_status);
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offer one word, with random idle cycles ahead of it; returns at the
    // edge where it was taken. Valid stays high: the caller either offers
    // the next word or lowers it.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        tracker.accept_byte(b);
        items_sent++;
    endtask

    // Sender pause until every expected result word is in
    task automatic drain_results();
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Length register is written only with the block drained; the frame
    // state in the block and in the tracker is left as it is.
    task automatic write_length(input logic [LEN_W-1:0] v);
        drain_results();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        tracker.length_reg = v;
        @(posedge clk);
    endtask

    // Start byte, body, CRC high then low; flip corrupts the sent CRC
    task automatic send_frame(input logic [7:0]  start,
                              input logic [7:0]  body[$],
                              input logic [15:0] flip);
        logic [15:0] crc;
        crc = CRC_INIT;
        send_byte(start);
        foreach (body[i])
        begin
            crc = frame_tracker::crc_step(crc, body[i]);
            send_byte(body[i]);
        end
        crc = crc ^ flip;
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
    endtask

    // Mostly clean frames; some with a bad start byte, a bad CRC or both
    task automatic send_random_frame();
        logic [7:0]  body[$];
        logic [7:0]  start;
        logic [15:0] flip;
        int unsigned kind;
        kind  = $urandom_range(99);
        start = START_BYTE;
        flip  = 16'h0000;
        if (kind < 10)
        begin
            start = 8'($urandom);
            if (start == START_BYTE)
                start = ~start;
        end
        if (kind < 5 || (kind >= 10 && kind < 25))
            flip = 16'h0001 << $urandom_range(15);
        repeat (tracker.effective_length())
            body.push_back(8'($urandom));
        send_frame(start, body, flip);
    endtask

    // Small lengths keep frames short; zero is common
    function automatic logic [LEN_W-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)
            return '0;
        if (r < 45)
            return LEN_W'($urandom_range(1, 3));
        return LEN_W'($urandom_range(4, 16));
    endfunction

    // One random phase: frames, length changes between frames and within
    // one, and stray bytes; afterwards random bytes until the frame
    // boundary is reached again.
    task automatic run_phase(input int unsigned snd,
                             input int unsigned rcv,
                             input int unsigned budget);
        int unsigned stop_at;
        int unsigned r;
        int unsigned n;
        send_idle_pct  = snd;
        recv_stall_pct = rcv;
        stop_at        = items_sent + budget;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 7)
                write_length(pick_length());
            else if (r < 11)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_byte(8'($urandom));
            end
            else if (r < 15)
            begin
                // partial frame, then a new length under way
                n = $urandom_range(0, tracker.effective_length());
                send_byte(START_BYTE);
                repeat (n)
                    send_byte(8'($urandom));
                write_length(pick_length());
            end
            else
                send_random_frame();
            while (tracker.position != 0)
                send_byte(8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [7:0] body[$];
        tracker = new();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero length: good CRC is the initial value, then a wrong one
        write_length('0);
        body = {};
        send_frame(START_BYTE, body, 16'h0000);
        send_frame(START_BYTE, body, 16'h0101);

        // extreme payload values, clean frame
        write_length(LEN_W'(2));
        body = {8'h00, 8'hFF};
        send_frame(START_BYTE, body, 16'h0000);

        // bad start and bad CRC together: start error wins
        body = {8'h12, 8'h34};
        send_frame(8'h00, body, 16'h8000);

        // bad start, good CRC; payload still passed out
        write_length(LEN_W'(1));
        body = {8'hAB};
        send_frame(8'hFF, body, 16'h0000);

        // length cut below the position mid-frame: next word ends the frame
        write_length(LEN_W'(3));
        send_byte(START_BYTE);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        write_length(LEN_W'(1));
        send_byte(8'h5A);

        // random part under two of the idle mixes
        run_phase(36, 46, 130);
        run_phase(46, 36, 130);

        // full register value saturates to the maximum payload; the receiver
        // holds off at the start of it while the sender keeps going
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_length('1);
        hold_go = 1'b1;
        send_random_frame();
        write_length(pick_length());
        run_phase(0, 0, 40);

        drain_results();
        repeat (8)
            @(posedge clk);
        if (tracker.error_count == 0 && tracker.pending_results.size() == 0)
            $display("** response_frame_crc_checker_unit: PASSED **");
        else
            $display("** response_frame_crc_checker_unit: FAILED **");
        $finish;
    end

    // Watchdog far beyond the slowest correct run
    initial
    begin
        #3_000_000;
        $display("** response_frame_crc_checker_unit: FAILED **");
        $finish;
    end

endmodule
